// ===== hw/rtl/bbm_pkg.sv =====
// Shared definitions for the radix-2 Booth multiplier.
// Holds the Booth recoding operation type and its decode function; no dependencies.
package bbm_pkg;

  typedef enum logic [1:0] {
    BOOTH_NOP,
    BOOTH_ADD,
    BOOTH_SUB
  } booth_op_e;

  // Recode the pair (current multiplier bit, bit below it).
  function automatic booth_op_e booth_decode(input logic cur, input logic prev);
    booth_op_e op;
    case ({cur, prev})
      2'b10:   op = BOOTH_SUB;
      2'b01:   op = BOOTH_ADD;
      default: op = BOOTH_NOP;
    endcase
    return op;
  endfunction

endpackage

// ===== hw/rtl/bbm_cell.sv =====
// One Booth step: add or subtract the multiplicand, then shift acc:q right arithmetically.
// Registers the result for the next cell of the chain. Depends on bbm_pkg.
module bbm_cell import bbm_pkg::*; #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [WIDTH:0]   mcand_i,
  input  logic [WIDTH:0]   acc_i,
  input  logic [WIDTH-1:0] q_i,
  input  logic             prev_i,
  output logic             valid_o,
  output logic [WIDTH:0]   mcand_o,
  output logic [WIDTH:0]   acc_o,
  output logic [WIDTH-1:0] q_o,
  output logic             prev_o
);

  booth_op_e        op;
  logic [WIDTH:0]   sum;
  logic             valid_q;
  logic [WIDTH:0]   mcand_q, mcand_d;
  logic [WIDTH:0]   acc_q, acc_d;
  logic [WIDTH-1:0] q_q, q_d;
  logic             prev_q, prev_d;

  always_comb begin
    op = booth_decode(q_i[0], prev_i);
    case (op)
      BOOTH_ADD: sum = acc_i + mcand_i;
      BOOTH_SUB: sum = acc_i - mcand_i;
      default:   sum = acc_i;
    endcase
    // The low accumulator bit moves into the top of the multiplier register.
    acc_d   = {sum[WIDTH], sum[WIDTH:1]};
    q_d     = {sum[0], q_i[WIDTH-1:1]};
    prev_d  = q_i[0];
    mcand_d = mcand_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q <= mcand_d;
    acc_q   <= acc_d;
    q_q     <= q_d;
    prev_q  <= prev_d;
  end

  assign valid_o = valid_q;
  assign mcand_o = mcand_q;
  assign acc_o   = acc_q;
  assign q_o     = q_q;
  assign prev_o  = prev_q;

endmodule

// ===== hw/rtl/booth_radix2_multiplier.sv =====
// done_o marks a word leaving the last registered cell of the chain.
// Throughput: one word per cycle; a chain of WIDTH Booth cells, one step per cell.
// busy_o stays low, so start_i is taken in every cycle; results cannot be stalled.
// Reset clears the valid bits of the chain; words in flight are dropped.
// Top level of the radix-2 Booth multiplier; depends on bbm_cell.
module booth_radix2_multiplier #(
  parameter int unsigned WIDTH = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic signed [WIDTH-1:0]     multiplicand_i,
  input  logic signed [WIDTH-1:0]     multiplier_i,
  output logic signed [2*WIDTH-1:0]   product_o,
  output logic                        done_o
);

  logic             valid_w [0:WIDTH];
  logic [WIDTH:0]   mcand_w [0:WIDTH];
  logic [WIDTH:0]   acc_w   [0:WIDTH];
  logic [WIDTH-1:0] q_w     [0:WIDTH];
  logic             prev_w  [0:WIDTH];

  assign busy_o     = 1'b0;
  assign valid_w[0] = start_i;
  assign mcand_w[0] = {multiplicand_i[WIDTH-1], multiplicand_i};
  assign acc_w[0]   = '0;
  assign q_w[0]     = multiplier_i;
  assign prev_w[0]  = 1'b0;

  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    bbm_cell #(
      .WIDTH(WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(valid_w[i]),
      .mcand_i(mcand_w[i]),
      .acc_i  (acc_w[i]),
      .q_i    (q_w[i]),
      .prev_i (prev_w[i]),
      .valid_o(valid_w[i+1]),
      .mcand_o(mcand_w[i+1]),
      .acc_o  (acc_w[i+1]),
      .q_o    (q_w[i+1]),
      .prev_o (prev_w[i+1])
    );
  end

  assign product_o = {acc_w[WIDTH][WIDTH-1:0], q_w[WIDTH]};
  assign done_o    = valid_w[WIDTH];

  a_done_has_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, WIDTH))
    else $error("done_o without a word accepted WIDTH cycles earlier");

  a_start_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##WIDTH done_o)
    else $error("accepted word produced no result");

  a_product_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (product_o ==
      $signed($past(multiplicand_i, WIDTH)) * $signed($past(multiplier_i, WIDTH))))
    else $error("product does not match the operands");

endmodule

// ===== tb/product_checker.sv =====
// Checker for the radix-2 Booth multiplier: watches the operand and product channels.
// Predicts each product with its own Booth step loop; uses booth_op_e from bbm_pkg.
module product_checker import bbm_pkg::*; #(
  parameter int unsigned WIDTH = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      busy_i,
  input  logic signed [WIDTH-1:0]   multiplicand_i,
  input  logic signed [WIDTH-1:0]   multiplier_i,
  input  logic signed [2*WIDTH-1:0] product_i,
  input  logic                      done_i,
  output int                        mismatch_count_o,
  output int                        products_checked_o,
  output int                        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [2*WIDTH-1:0] expected_products[$];

  initial begin
    mismatch_count_o   = 0;
    products_checked_o = 0;
    pending_o          = 0;
  end

  // One Booth step per multiplier bit on a WIDTH+1 bit accumulator, so that
  // subtracting the most negative multiplicand cannot overflow.
  function automatic logic signed [2*WIDTH-1:0] booth_product(
    input logic [WIDTH-1:0] mcand,
    input logic [WIDTH-1:0] mplier
  );
    logic [WIDTH:0]   acc;
    logic [WIDTH:0]   mcand_ext;
    logic [WIDTH-1:0] q;
    logic             prev;
    booth_op_e        op;
    int               step;
    mcand_ext = {mcand[WIDTH-1], mcand};
    acc       = '0;
    q         = mplier;
    prev      = 1'b0;
    for (step = 0; step < WIDTH; step++) begin
      if (q[0] && !prev) begin
        op = BOOTH_SUB;
      end else if (!q[0] && prev) begin
        op = BOOTH_ADD;
      end else begin
        op = BOOTH_NOP;
      end
      if (op == BOOTH_SUB) begin
        acc = acc - mcand_ext;
      end else if (op == BOOTH_ADD) begin
        acc = acc + mcand_ext;
      end
      prev = q[0];
      q    = {acc[0], q[WIDTH-1:1]};
      acc  = {acc[WIDTH], acc[WIDTH:1]};
    end
    return {acc[WIDTH-1:0], q};
  endfunction

  task automatic report_mismatch(input string what, input logic signed [2*WIDTH-1:0] want,
                                 input logic signed [2*WIDTH-1:0] got);
    $display("[%0t] product mismatch: %s (expected %0d, got %0d)", $realtime, what, want, got);
    mismatch_count_o++;
  endtask

  always @(posedge clk_i) begin
    logic signed [2*WIDTH-1:0] want;
    if (rst_ni) begin
      if (start_i && !busy_i) begin
        expected_products.push_back(booth_product(multiplicand_i, multiplier_i));
      end
      if (done_i) begin
        if (expected_products.size() == 0) begin
          report_mismatch("word with none outstanding", '0, product_i);
        end else begin
          want = expected_products.pop_front();
          if (product_i !== want) begin
            report_mismatch("wrong product", want, product_i);
          end
          products_checked_o++;
        end
      end
      pending_o <= expected_products.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the Booth multiplier testbench: clock, reset, operand stimulus and verdict.
// Depends on booth_radix2_multiplier, product_checker and bbm_pkg.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WIDTH       = 8;
  localparam int          RANDOM_WORDS = 550;
  localparam int          CYCLE_LIMIT  = 40000;

  logic                      clk_i          = 1'b0;
  logic                      rst_ni         = 1'b0;
  logic                      start_i        = 1'b0;
  logic signed [WIDTH-1:0]   multiplicand_i = '0;
  logic signed [WIDTH-1:0]   multiplier_i   = '0;
  logic                      busy_o;
  logic signed [2*WIDTH-1:0] product_o;
  logic                      done_o;

  int mismatch_count;
  int products_checked;
  int pending;
  int cycle_count    = 0;
  int words_sent     = 0;
  int directed_words = 0;
  bit idle_enable    = 1'b1;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  booth_radix2_multiplier #(.WIDTH(WIDTH)) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .multiplicand_i(multiplicand_i),
    .multiplier_i  (multiplier_i),
    .product_o     (product_o),
    .done_o        (done_o)
  );

  product_checker #(.WIDTH(WIDTH)) u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_i            (busy_o),
    .multiplicand_i    (multiplicand_i),
    .multiplier_i      (multiplier_i),
    .product_i         (product_o),
    .done_i            (done_o),
    .mismatch_count_o  (mismatch_count),
    .products_checked_o(products_checked),
    .pending_o         (pending)
  );

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d products outstanding.", pending);
      $display("FAIL");
      $finish;
    end
  end

  // Random idle cycles with start low carry junk operands, which must be ignored.
  task automatic send_word(input logic signed [WIDTH-1:0] mcand,
                           input logic signed [WIDTH-1:0] mplier);
    while (idle_enable && $urandom_range(99) < 23) begin
      start_i        <= 1'b0;
      multiplicand_i <= WIDTH'($urandom);
      multiplier_i   <= WIDTH'($urandom);
      @(posedge clk_i);
    end
    start_i        <= 1'b1;
    multiplicand_i <= mcand;
    multiplier_i   <= mplier;
    @(posedge clk_i);
    while (busy_o) begin
      @(posedge clk_i);
    end
    words_sent++;
  endtask

  // Mostly uniform operands, with both extremes and the values 0, 1, -1 and -2
  // mixed in.
  function automatic logic signed [WIDTH-1:0] pick_operand();
    logic signed [WIDTH-1:0] value;
    case ($urandom_range(9))
      0:       value = {1'b1, {(WIDTH-1){1'b0}}};
      1:       value = {1'b0, {(WIDTH-1){1'b1}}};
      2:       value = '1;
      3:       value = WIDTH'($urandom_range(1)) ^ {WIDTH{$urandom_range(1) == 1}};
      default: value = WIDTH'($urandom);
    endcase
    return value;
  endfunction

  initial begin
    logic signed [WIDTH-1:0] min_val;
    logic signed [WIDTH-1:0] max_val;
    logic signed [WIDTH-1:0] alt_01;
    logic signed [WIDTH-1:0] alt_10;
    int i;
    min_val = {1'b1, {(WIDTH-1){1'b0}}};
    max_val = {1'b0, {(WIDTH-1){1'b1}}};
    alt_01  = {(WIDTH/2){2'b01}};
    alt_10  = {(WIDTH/2){2'b10}};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words: zeros, ones, both extremes (the most negative squared
    // among them), and alternating bits that recode to a step at every bit above bit 0.
    send_word('0, '0);
    send_word(min_val, min_val);
    send_word(min_val, max_val);
    send_word(max_val, min_val);
    send_word(max_val, max_val);
    send_word('1, '1);
    send_word(WIDTH'(1), '1);
    send_word(min_val, WIDTH'(1));
    send_word(WIDTH'(1), min_val);
    send_word('0, min_val);
    send_word(min_val, '0);
    send_word(min_val, alt_01);
    send_word(min_val, alt_10);
    send_word(max_val, alt_10);
    send_word(alt_01, alt_10);
    send_word('1, min_val);
    send_word(min_val, '1);
    send_word(WIDTH'(1), WIDTH'(1));
    directed_words = words_sent;

    for (i = 0; i < RANDOM_WORDS; i++) begin
      // A long back-to-back stretch in the middle of the random part.
      idle_enable = !(i >= 200 && i < 330);
      send_word(pick_operand(), pick_operand());
    end
    start_i <= 1'b0;

    do begin
      @(posedge clk_i);
    end while (pending != 0);
    repeat (WIDTH + 4) @(posedge clk_i);

    $display("Sent %0d operand words (%0d directed, %0d random).",
             words_sent, directed_words, words_sent - directed_words);
    $display("Compared %0d products; %0d mismatches.", products_checked, mismatch_count);
    if (mismatch_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
